/* sv/isp_pkg.sv */
// shared types and constants of the interpolating sample player
package isp_pkg;

  // field widths of the stream items
  localparam int REQ_W      = 2;
  localparam int INDEX_W    = 16;
  localparam int SAMP_W     = 16;
  localparam int CHSEL_W    = 3;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  // configuration register widths
  localparam int CHCNT_W    = 4;
  localparam int FRAME_W    = 17;
  localparam int STEP_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // play position, two's complement
  localparam int POS_W      = 40;

  // register reset values
  localparam logic [CHCNT_W-1:0]       CHCNT_RESET = 4'd1;
  localparam logic [FRAME_W-1:0]       FRAME_RESET = 17'd1;
  localparam logic signed [STEP_W-1:0] STEP_RESET  = 24'sd65536;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 2'd2;

  // tick sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD0,
    ST_RD1,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

endpackage

/* sv/interpolating_sample_player_unit.sv */
// interpolating sample player top level: request decode, tick sequencer, output register
//
//  channel   dir  tdata (low bit up)                          tuser
//  s_axis    in   sample_index, sample_value, channel_select  req_type
//  m_axis    out  sample_out                                  finished_flag
//  cfg       in   cfg_index selects, cfg_data carries value   -
//
// write, restart and unknown requests are handled in idle; the block is ready again next cycle.
// a tick goes through check, two reads of the one memory read port, multiply, add and output
// load; a finished, out of range or absent channel tick skips from check to output load.
// reset clears position, finished latch, configuration registers and output valid; memory is not cleared.
// a tick waits in its last step while the output register still holds an untaken result.
// SAMPLE_DEPTH is a power of two; addresses wrap on its width.
module interpolating_sample_player_unit #(
  parameter int SAMPLE_DEPTH = 65536,
  parameter int MAX_CHANNELS = 8,
  parameter int FRAC_BITS    = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [isp_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // sample_index, sample_value, channel_select, zero fill
  input  logic [isp_pkg::REQ_W-1:0]          s_axis_tuser,  // req_type
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [isp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // sample_out
  output logic [0:0]                         m_axis_tuser,  // finished_flag
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [isp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [isp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  // frame index bits of a non-negative position
  localparam int IDX_W  = isp_pkg::POS_W - 1 - FRAC_BITS;
  localparam int LIN_W  = IDX_W + CNT_W + 1;
  localparam int CMP_W  = ((isp_pkg::POS_W > isp_pkg::FRAME_W + 1 + FRAC_BITS) ?
                           isp_pkg::POS_W : isp_pkg::FRAME_W + 1 + FRAC_BITS) + 1;
  localparam int DIFF_W = isp_pkg::SAMP_W + 1;
  localparam int PROD_W = FRAC_BITS + 1 + DIFF_W;

  isp_pkg::state_t state, state_next;

  // configuration registers
  logic [isp_pkg::CHCNT_W-1:0]       channel_count;
  logic [isp_pkg::FRAME_W-1:0]       frame_count;
  logic signed [isp_pkg::STEP_W-1:0] step_rate;

  // playback state
  logic signed [isp_pkg::POS_W-1:0]  pos;
  logic                              fin;

  // tick working registers
  logic [isp_pkg::CHSEL_W-1:0]       chan_sel;
  logic [ADDR_W-1:0]                 addr;
  logic signed [isp_pkg::SAMP_W-1:0] s0;
  logic signed [PROD_W-1:0]          prod;
  logic signed [isp_pkg::SAMP_W-1:0] res_sample;
  logic                              res_fin;

  // memory port
  logic                              mem_wr;
  logic                              mem_rd;
  logic signed [isp_pkg::SAMP_W-1:0] mem_rdata;

  // request fields
  logic [isp_pkg::INDEX_W-1:0]       in_index;
  logic signed [isp_pkg::SAMP_W-1:0] in_value;
  logic [isp_pkg::CHSEL_W-1:0]       in_chan;
  logic                              in_accept;
  logic                              out_free;

  // tick datapath
  logic [CNT_W-1:0]                  chans;
  logic                              present;
  logic signed [isp_pkg::FRAME_W:0]  fc_m1;
  logic signed [CMP_W-1:0]           last_pos;
  logic signed [CMP_W-1:0]           pos_ext;
  logic                              out_range;
  logic [IDX_W-1:0]                  fidx;
  logic [FRAC_BITS-1:0]              frac;
  logic [LIN_W-1:0]                  lin;
  logic [ADDR_W-1:0]                 addr0;
  logic signed [DIFF_W-1:0]          diff;
  logic signed [PROD_W-1:0]          prod_shift;
  logic signed [isp_pkg::POS_W-1:0]  pos_adv;

  assign in_index  = s_axis_tdata[isp_pkg::INDEX_W-1:0];
  assign in_value  = s_axis_tdata[isp_pkg::INDEX_W +: isp_pkg::SAMP_W];
  assign in_chan   = s_axis_tdata[isp_pkg::INDEX_W + isp_pkg::SAMP_W +: isp_pkg::CHSEL_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= isp_pkg::CHCNT_RESET;
      frame_count   <= isp_pkg::FRAME_RESET;
      step_rate     <= isp_pkg::STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        isp_pkg::CFG_CHANNELS: channel_count <= cfg_data[isp_pkg::CHCNT_W-1:0];
        isp_pkg::CFG_FRAMES:   frame_count   <= cfg_data[isp_pkg::FRAME_W-1:0];
        isp_pkg::CFG_STEP:     step_rate     <= $signed(cfg_data[isp_pkg::STEP_W-1:0]);
        default: ;
      endcase
    end
  end

  // effective channel count, clamped to one..MAX_CHANNELS
  always_comb begin
    priority if (channel_count == '0) begin
      chans = CNT_W'(1);
    end else if (channel_count > MAX_CHANNELS) begin
      chans = CNT_W'(MAX_CHANNELS);
    end else begin
      chans = CNT_W'(channel_count);
    end
  end

  assign present = chan_sel < chans;

  // valid range is zero up to the last frame's position
  assign fc_m1     = {1'b0, frame_count} - 1'b1;
  assign last_pos  = CMP_W'(fc_m1) <<< FRAC_BITS;
  assign pos_ext   = CMP_W'(pos);
  assign out_range = (pos_ext < 0) || (pos_ext > last_pos);

  // word address of the current frame for the selected channel
  assign fidx  = pos[FRAC_BITS +: IDX_W];
  assign frac  = pos[FRAC_BITS-1:0];
  assign lin   = LIN_W'(fidx) * LIN_W'(chans) + LIN_W'(chan_sel);
  assign addr0 = ADDR_W'(lin);

  // weighted difference; an exact frame ignores the next word
  assign diff       = (frac == '0) ? '0 : (DIFF_W'(mem_rdata) - DIFF_W'(s0));
  assign prod_shift = prod >>> FRAC_BITS;
  assign pos_adv    = pos + isp_pkg::POS_W'(step_rate);

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory controls
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    mem_wr        = 1'b0;
    mem_rd        = 1'b0;
    unique case (state)
      isp_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        mem_wr = s_axis_tvalid && (s_axis_tuser == isp_pkg::REQ_WRITE);
        if (s_axis_tvalid && (s_axis_tuser == isp_pkg::REQ_TICK)) begin
          state_next = isp_pkg::ST_CHECK;
        end
      end
      isp_pkg::ST_CHECK: begin
        if (fin || out_range || !present) begin
          state_next = isp_pkg::ST_DONE;
        end else begin
          state_next = isp_pkg::ST_RD0;
        end
      end
      isp_pkg::ST_RD0: begin
        mem_rd     = 1'b1;
        state_next = isp_pkg::ST_RD1;
      end
      isp_pkg::ST_RD1: begin
        mem_rd     = 1'b1;
        state_next = isp_pkg::ST_MUL;
      end
      isp_pkg::ST_MUL: begin
        state_next = isp_pkg::ST_ADD;
      end
      isp_pkg::ST_ADD: begin
        state_next = isp_pkg::ST_DONE;
      end
      isp_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = isp_pkg::ST_IDLE;
        end
      end
      default: state_next = isp_pkg::ST_IDLE;
    endcase
  end

  // playback control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      fin <= 1'b0;
    end else begin
      unique case (state)
        isp_pkg::ST_IDLE: begin
          if (in_accept && (s_axis_tuser == isp_pkg::REQ_RESTART)) begin
            pos <= '0;
            fin <= 1'b0;
          end
        end
        isp_pkg::ST_CHECK: begin
          priority if (fin || out_range) begin
            fin <= 1'b1;
          end else if (!present) begin
            pos <= pos_adv;
          end
        end
        isp_pkg::ST_ADD: pos <= pos_adv;
        default: ;
      endcase
    end
  end

  // tick datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      isp_pkg::ST_IDLE: begin
        if (in_accept) begin
          chan_sel <= in_chan;
        end
      end
      isp_pkg::ST_CHECK: begin
        addr <= addr0;
        priority if (fin || out_range) begin
          res_sample <= '0;
          res_fin    <= 1'b1;
        end else begin
          res_sample <= '0;
          res_fin    <= 1'b0;
        end
      end
      isp_pkg::ST_RD0: addr <= ADDR_W'(addr + ADDR_W'(chans));
      isp_pkg::ST_RD1: s0 <= mem_rdata;
      isp_pkg::ST_MUL: prod <= PROD_W'($signed({1'b0, frac})) * PROD_W'(diff);
      isp_pkg::ST_ADD: res_sample <= s0 + isp_pkg::SAMP_W'(prod_shift);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == isp_pkg::ST_DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == isp_pkg::ST_DONE) && out_free) begin
      m_axis_tdata <= res_sample;
      m_axis_tuser <= res_fin;
    end
  end

  // sample store
  isp_sample_mem #(
    .DEPTH(SAMPLE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (ADDR_W'(in_index)),
    .wr_data (in_value),
    .rd_en   (mem_rd),
    .rd_addr (addr),
    .rd_data (mem_rdata)
  );

endmodule

/* sv/isp_sample_mem.sv */
// sample memory with one write port, one read port and registered read data
module isp_sample_mem #(
  parameter int DEPTH = 65536,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [ADDR_W-1:0]                   wr_addr,
  input  logic signed [isp_pkg::SAMP_W-1:0]   wr_data,
  input  logic                                rd_en,
  input  logic [ADDR_W-1:0]                   rd_addr,
  output logic signed [isp_pkg::SAMP_W-1:0]   rd_data
);

  logic signed [isp_pkg::SAMP_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/isp_check.sv */
// port level checks of the sample player, bound to the top level
module isp_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [isp_pkg::REQ_W-1:0]      s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [isp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]                     m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a finished result carries a zero sample
  a_fin_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("finished result with nonzero sample");

  // a tick keeps the block busy in the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == isp_pkg::REQ_TICK) |=> !s_axis_tready)
    else $error("ready right after a tick");

  // other requests leave the block ready in the next cycle
  a_other_quick: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != isp_pkg::REQ_TICK) |=> s_axis_tready)
    else $error("not ready after a one cycle request");

endmodule

bind interpolating_sample_player_unit isp_check u_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* test/interpolating_sample_player_check.sv */
`timescale 1ns / 1ps
// playback predictor and result comparison for the interpolating sample player
module interpolating_sample_player_check
  import isp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // sample_index, sample_value, channel_select, zero fill
  input  logic [REQ_W-1:0]      s_axis_tuser,  // req_type
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,  // sample_out
  input  logic [0:0]            m_axis_tuser,  // finished_flag
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    pending_samples
);

  localparam int FRAC      = 16;
  localparam int MEM_DEPTH = 65536;
  localparam int MAX_CH    = 8;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic signed [SAMP_W-1:0] sample;
    logic                     finished;
  } played_t;

  // predictor state
  logic [SAMP_W-1:0]        sample_mem [MEM_DEPTH];
  logic signed [POS_W-1:0]  position;
  logic                     done_latch;
  logic [CHCNT_W-1:0]       chans_reg;
  logic [FRAME_W-1:0]       frames_reg;
  logic signed [STEP_W-1:0] step_reg;
  played_t                  expected_q [$];

  // one tick: interpolated sample of the chosen channel, then advance the position
  function automatic played_t play_tick(input logic [CHSEL_W-1:0] chan);
    played_t               r;
    longint                last_pos;
    longint                prod;
    int unsigned           nch;
    logic [INDEX_W-1:0]    a0;
    logic signed [SAMP_W-1:0] s0;
    logic signed [SAMP_W-1:0] s1;
    last_pos = (longint'(frames_reg) - 1) <<< FRAC;
    if (!done_latch && (longint'(position) < 0 || longint'(position) > last_pos))
      done_latch = 1'b1;
    r.finished = done_latch;
    r.sample   = '0;
    if (!done_latch) begin
      nch = (chans_reg == 0) ? 1 : ((chans_reg > MAX_CH) ? MAX_CH : chans_reg);
      if (chan < nch) begin
        a0 = INDEX_W'(longint'(position[POS_W-1:FRAC]) * nch + chan);
        s0 = sample_mem[a0];
        r.sample = s0;
        // fractional position weighs the step to the next frame, floored
        if (position[FRAC-1:0] != 0) begin
          s1 = sample_mem[INDEX_W'(a0 + nch)];
          prod = longint'(position[FRAC-1:0]) * (longint'(s1) - longint'(s0));
          r.sample = SAMP_W'(longint'(s0) + (prod >>> FRAC));
        end
      end
      position = position + step_reg;
    end
    return r;
  endfunction

  task automatic report(input string msg);
    if (mismatch_count < MAX_SHOWN)
      $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    played_t want;
    if (rst) begin
      position   = '0;
      done_latch = 1'b0;
      chans_reg  = CHCNT_RESET;
      frames_reg = FRAME_RESET;
      step_reg   = STEP_RESET;
      expected_q.delete();
    end else begin
      // result side: compare against the oldest expected sample
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result sample %0d finished %0b",
                           $signed(m_axis_tdata), m_axis_tuser[0]));
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata !== want.sample || m_axis_tuser[0] !== want.finished)
            report($sformatf("result mismatch: expected sample %0d finished %0b, got %0d %0b",
                             want.sample, want.finished, $signed(m_axis_tdata),
                             m_axis_tuser[0]));
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHANNELS: chans_reg = cfg_data[CHCNT_W-1:0];
          CFG_FRAMES:   frames_reg = cfg_data[FRAME_W-1:0];
          CFG_STEP:     step_reg = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      // request side
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          REQ_WRITE:   sample_mem[s_axis_tdata[INDEX_W-1:0]] =
                         s_axis_tdata[INDEX_W +: SAMP_W];
          REQ_TICK:    expected_q.push_back(play_tick(s_axis_tdata[INDEX_W+SAMP_W +: CHSEL_W]));
          REQ_RESTART: begin
            position   = '0;
            done_latch = 1'b0;
          end
          default: ;
        endcase
      end
    end
    pending_samples = expected_q.size();
  end

endmodule

/* test/interpolating_sample_player_unit_test.sv */
`timescale 1ns / 1ps
// stimulus, flow control and verdict for the interpolating sample player
module interpolating_sample_player_unit_test;
  import isp_pkg::*;

  localparam int FRAC         = 16;
  localparam int MEM_DEPTH    = 65536;
  localparam int MAX_CH       = 8;
  localparam int RANDOM_ITEMS = 450;
  localparam int CALM_ITEMS   = 80;
  localparam int SETTLE       = 12;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TIMEOUT_NS   = 8_000_000;

  // request code the block must ignore
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [REQ_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    pending;

  // flow control switches shared by the sender and the receiver
  bit calm;
  bit hold_long;

  // requests accepted so far, every kind counted
  int sent_items;

  // what the stimulus knows about the block, to keep reads on written words
  bit                       wrote [MEM_DEPTH];
  logic [CHCNT_W-1:0]       chans_set;
  logic [FRAME_W-1:0]       frames_set;
  logic signed [STEP_W-1:0] step_set;
  longint                   play_pos;
  bit                       play_done;

  interpolating_sample_player_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  interpolating_sample_player_check playback_check (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatches),
    .pending_samples (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop
  initial begin
    #(TIMEOUT_NS);
    $display("interpolating_sample_player_unit_test: done, errors");
    $finish;
  end

  // result receiver: random stall bursts, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_long) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  function automatic int unsigned active_channels(input logic [CHCNT_W-1:0] c);
    if (c == 0)
      return 1;
    if (c > MAX_CH)
      return MAX_CH;
    return c;
  endfunction

  // mostly random, sometimes a full-scale value
  function automatic logic [SAMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return SAMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [CHSEL_W-1:0] pick_chan();
    if ($urandom_range(0, 4) == 0)
      return CHSEL_W'($urandom_range(0, 7));
    return CHSEL_W'($urandom_range(0, active_channels(chans_set) - 1));
  endfunction

  // offer one request and hold it until accepted, then maybe idle a burst
  task automatic put_req(input logic [REQ_W-1:0] req, input logic [INDEX_W-1:0] idx,
                         input logic [SAMP_W-1:0] val, input logic [CHSEL_W-1:0] ch);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {{(IN_DATA_W-INDEX_W-SAMP_W-CHSEL_W){1'b0}}, ch, val, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    sent_items++;
    if (req == REQ_WRITE)
      wrote[idx] = 1'b1;
    if (req == REQ_RESTART) begin
      play_pos  = 0;
      play_done = 1'b0;
    end
    if (!calm && !hold_long && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic fill_word(input logic [INDEX_W-1:0] addr);
    if (!wrote[addr])
      put_req(REQ_WRITE, addr, rand_sample(), CHSEL_W'($urandom));
  endtask

  // tick request, after writing any word the tick will read
  task automatic do_tick(input logic [CHSEL_W-1:0] ch);
    longint             last_pos;
    int unsigned        nch;
    logic [INDEX_W-1:0] a0;
    last_pos = (longint'(frames_set) - 1) * 65536;
    if (!play_done && (play_pos < 0 || play_pos > last_pos))
      play_done = 1'b1;
    if (!play_done) begin
      nch = active_channels(chans_set);
      if (ch < nch) begin
        a0 = INDEX_W'((play_pos >>> FRAC) * nch + ch);
        fill_word(a0);
        if (play_pos[FRAC-1:0] != 0)
          fill_word(INDEX_W'(a0 + nch));
      end
      play_pos = play_pos + step_set;
      play_pos = longint'($signed(play_pos[POS_W-1:0]));
    end
    put_req(REQ_TICK, INDEX_W'($urandom), SAMP_W'($urandom), ch);
  endtask

  // drain all expected samples and let the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // write all three registers back to back while the block is idle
  task automatic configure(input logic [CHCNT_W-1:0] ch, input logic [FRAME_W-1:0] fr,
                           input logic signed [STEP_W-1:0] st);
    logic [CFG_IDX_W-1:0]  regs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    int                    k;
    settle();
    regs = '{CFG_CHANNELS, CFG_FRAMES, CFG_STEP};
    vals = '{CFG_DATA_W'(ch), CFG_DATA_W'(fr), CFG_DATA_W'(st)};
    for (k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid  <= 1'b0;
    chans_set  = ch;
    frames_set = fr;
    step_set   = st;
  endtask

  initial begin
    int                       phase;
    int                       n;
    int                       k;
    int                       r;
    int                       drain;
    logic [CHCNT_W-1:0]       ch_pick;
    logic [FRAME_W-1:0]       fr_pick;
    logic signed [STEP_W-1:0] st_pick;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_WRITE;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_CHANNELS;
    cfg_data      = '0;
    calm          = 1'b0;
    hold_long     = 1'b0;
    chans_set     = CHCNT_RESET;
    frames_set    = FRAME_RESET;
    step_set      = STEP_RESET;
    play_pos      = 0;
    play_done     = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset settings: exact frame, leaving the range, finished, restart, absent channel
    put_req(REQ_WRITE, 16'd0, 16'h7fff, 3'd0);
    do_tick(3'd0);
    do_tick(3'd0);
    do_tick(3'd0);
    put_req(REQ_UNUSED, 16'hffff, 16'hffff, 3'd7);
    put_req(REQ_RESTART, 16'd0, 16'd0, 3'd0);
    do_tick(3'd1);
    do_tick(3'd0);

    // two channels, fractional step across full-scale swings
    configure(4'd2, 17'd3, 24'sd40000);
    put_req(REQ_WRITE, 16'd0, 16'h8000, 3'd0);
    put_req(REQ_WRITE, 16'd1, 16'h7fff, 3'd0);
    put_req(REQ_WRITE, 16'd2, 16'h7fff, 3'd0);
    put_req(REQ_WRITE, 16'd3, 16'h8000, 3'd0);
    put_req(REQ_WRITE, 16'd4, 16'h0000, 3'd0);
    put_req(REQ_WRITE, 16'd5, 16'hffff, 3'd0);
    put_req(REQ_RESTART, 16'd0, 16'd0, 3'd0);
    repeat (3) begin
      do_tick(3'd0);
      do_tick(3'd1);
    end

    // zero frame count finishes on the first tick
    configure(4'd1, 17'd0, -24'sd1);
    do_tick(3'd0);

    // random phases, a few fixed extremes first
    phase = 0;
    while (sent_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          // widest frame, largest step: addresses wrap around memory
          ch_pick = 4'd8;
          fr_pick = 17'h10000;
          st_pick = 24'h7fffff;
          n       = 75;
        end
        1: begin
          ch_pick = 4'd15;
          fr_pick = 17'h1ffff;
          st_pick = 24'h800000;
          n       = 20;
        end
        2: begin
          ch_pick = 4'd0;
          fr_pick = 17'd0;
          st_pick = '0;
          n       = 15;
        end
        3: begin
          ch_pick = 4'd1;
          fr_pick = 17'd200;
          st_pick = 24'sd16384;
          n       = 40;
        end
        default: begin
          ch_pick = ($urandom_range(0, 5) == 0) ? CHCNT_W'($urandom)
                                                : CHCNT_W'($urandom_range(1, MAX_CH));
          case ($urandom_range(0, 9))
            0:       fr_pick = FRAME_W'($urandom);
            1:       fr_pick = 17'h10000;
            2:       fr_pick = FRAME_W'($urandom_range(0, 2));
            default: fr_pick = FRAME_W'($urandom_range(2, 48));
          endcase
          case ($urandom_range(0, 9))
            0:       st_pick = STEP_W'($urandom);
            1:       st_pick = -STEP_W'($urandom_range(1, 65536));
            2:       st_pick = STEP_W'($urandom_range(0, 65535));
            3:       st_pick = 24'sd65536;
            4:       st_pick = '0;
            default: st_pick = STEP_W'($urandom_range(1, 3 * 65536));
          endcase
          n = $urandom_range(20, 50);
        end
      endcase
      configure(ch_pick, fr_pick, st_pick);
      // receiver holds off while ticks keep coming, filling the block
      if (phase == 3)
        hold_long = 1'b1;
      if ($urandom_range(0, 4) != 0)
        put_req(REQ_RESTART, INDEX_W'($urandom), SAMP_W'($urandom), CHSEL_W'($urandom));
      for (k = 0; k < n && sent_items < RANDOM_ITEMS; k++) begin
        if (sent_items >= RANDOM_ITEMS - CALM_ITEMS)
          calm = 1'b1;
        r = $urandom_range(0, 99);
        if (r >= 96)
          put_req(REQ_UNUSED, INDEX_W'($urandom), SAMP_W'($urandom), CHSEL_W'($urandom));
        else if (r < 72)
          do_tick(pick_chan());
        else if (r < 86)
          put_req(REQ_WRITE, INDEX_W'($urandom), rand_sample(), CHSEL_W'($urandom));
        else
          put_req(REQ_RESTART, INDEX_W'($urandom), SAMP_W'($urandom), CHSEL_W'($urandom));
      end
      phase++;
    end

    // drain, then verdict
    s_axis_tvalid <= 1'b0;
    for (drain = 0; drain < DRAIN_LIMIT && pending != 0; drain++) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (pending != 0)
      $display("%0d expected samples never arrived", pending);
    if (mismatches == 0 && pending == 0)
      $display("interpolating_sample_player_unit_test: done, clean");
    else
      $display("interpolating_sample_player_unit_test: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
sv/isp_pkg.sv
sv/isp_sample_mem.sv
sv/interpolating_sample_player_unit.sv
sv/isp_check.sv
test/interpolating_sample_player_check.sv
test/interpolating_sample_player_unit_test.sv
